// ----- rtl/pcm_pkg.sv -----
// Package for the probabilistic clock multiplier: widths, register indexes,
// reset values and output level codes. No dependencies.
package pcm_pkg;

   // Width of the tick counter and of the measured period.
   localparam int COUNT_WIDTH = 24;
   // Twice a five-bit factor needs six bits, so the dividend is this much wider than the count.
   localparam int MULT_WIDTH  = 6;
   localparam int NUM_WIDTH   = COUNT_WIDTH + MULT_WIDTH;
   localparam int STEP_WIDTH  = $clog2(NUM_WIDTH);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUM_WIDTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLOCK_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAIN_MULT       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BLOCK_MULT      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PASS_PROB       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MULT_PROB       = 3'd4;

   // Register reset values.
   localparam logic signed [11:0] THRESHOLD_RESET = 12'sd410;
   localparam logic [4:0]  MULT_RESET = 5'd1;
   localparam logic [16:0] PROB_RESET = 17'd65536;

   // Modified output levels.
   localparam logic [1:0] LEVEL_LOW   = 2'd0;
   localparam logic [1:0] LEVEL_UNITY = 2'd1;
   localparam logic [1:0] LEVEL_MULT  = 2'd2;

endpackage

// ----- rtl/probabilistic_clock_multiplier_unit.sv -----
// Top level of the probabilistic clock multiplier: edge detection, period
// measurement and two bit-serial restoring dividers. Depends on pcm_pkg.
//
// Each accepted item runs through the dividers, which retire one dividend bit per
// cycle, and its result waits at the last step until the output register is free.
// The block takes no new item until that result has been loaded.
// Reset (synchronous, active high) restores the register defaults and the
// tracking state; the block accepts an item in the first cycle after reset.
module probabilistic_clock_multiplier_unit
   import pcm_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [11:0]                req_clk_sample,
   input  logic        [15:0]                req_rand_pass,
   input  logic        [15:0]                req_rand_mult,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [11:0]                rsp_through_sample,
   output logic                              rsp_main_high,
   output logic        [1:0]                 rsp_modified_level,
   // Configuration port
   input  logic                              csr_write_en,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   // Configuration registers.
   logic signed [11:0] threshold_ff;
   logic [4:0]         main_mult_ff;
   logic [4:0]         block_mult_ff;
   logic [16:0]        pass_prob_ff;
   logic [16:0]        mult_prob_ff;

   // Tracking state.
   logic                   was_high_ff, was_high_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic                   gated_ff, gated_in;
   logic                   unity_ff, unity_in;

   // Sequencer and divider datapath.
   logic                   state_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [NUM_WIDTH-1:0]   num_main_ff, num_mod_ff;
   logic [COUNT_WIDTH:0]   rem_main_ff, rem_mod_ff;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic signed [11:0]     sample_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic signed [11:0]     out_sample_ff;
   logic                   out_main_ff;
   logic [1:0]             out_level_ff;

   logic                   accept;
   logic                   clk_high;
   logic                   rise;
   logic [COUNT_WIDTH-1:0] tick_inc;
   logic [MULT_WIDTH-1:0]  mod_mult2;
   logic [COUNT_WIDTH:0]   rem_main_in, rem_mod_in;
   logic                   q_main, q_mod;
   logic                   last_step;
   logic                   can_load;
   logic [1:0]             level_in;

   // One restoring division step: returns the new remainder and quotient bit.
   function automatic logic [COUNT_WIDTH+1:0] div_step(
      input logic [COUNT_WIDTH:0]   rem,
      input logic                   num_bit,
      input logic [COUNT_WIDTH-1:0] div
   );
      logic [COUNT_WIDTH:0] shifted;
      logic                 ge;
      shifted = {rem[COUNT_WIDTH-1:0], num_bit};
      ge      = shifted >= {1'b0, div};
      div_step = {ge ? shifted - {1'b0, div} : shifted, ge};
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff == ST_DIV);
   assign last_step = (step_ff == LAST_STEP);
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   // Edge detection and period tracking for the item being accepted.
   always_comb begin
      clk_high    = req_clk_sample > threshold_ff;
      rise        = clk_high && !was_high_ff;
      tick_inc    = (tick_ff != COUNT_MAX) ? tick_ff + 1'b1 : tick_ff;
      was_high_in = clk_high;
      tick_in     = rise ? '0 : tick_inc;
      period_in   = rise ? tick_inc : period_ff;
      gated_in    = rise ? ({1'b0, req_rand_pass} > pass_prob_ff) : gated_ff;
      unity_in    = rise ? ({1'b0, req_rand_mult} > mult_prob_ff) : unity_ff;
      mod_mult2   = unity_in ? MULT_WIDTH'(2) : {block_mult_ff, 1'b0};
   end

   // Both dividers share the divisor and step together.
   always_comb begin
      {rem_main_in, q_main} = div_step(rem_main_ff, num_main_ff[NUM_WIDTH-1], divisor_ff);
      {rem_mod_in, q_mod}   = div_step(rem_mod_ff, num_mod_ff[NUM_WIDTH-1], divisor_ff);
      // Unless the item is gated, the output is high when the quotient is even.
      if (gated_ff) begin
         level_in = LEVEL_LOW;
      end else if (unity_ff) begin
         level_in = q_mod ? LEVEL_LOW : LEVEL_UNITY;
      end else begin
         level_in = q_mod ? LEVEL_LOW : LEVEL_MULT;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         main_mult_ff  <= MULT_RESET;
         block_mult_ff <= MULT_RESET;
         pass_prob_ff  <= PROB_RESET;
         mult_prob_ff  <= PROB_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_CLOCK_THRESHOLD: threshold_ff  <= csr_wdata[11:0];
            REG_MAIN_MULT:       main_mult_ff  <= csr_wdata[4:0];
            REG_BLOCK_MULT:      block_mult_ff <= csr_wdata[4:0];
            REG_PASS_PROB:       pass_prob_ff  <= csr_wdata;
            REG_MULT_PROB:       mult_prob_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tracking state advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         was_high_ff <= 1'b0;
         tick_ff     <= COUNT_WIDTH'(1);
         period_ff   <= COUNT_WIDTH'(1);
         gated_ff    <= 1'b1;
         unity_ff    <= 1'b1;
      end else if (accept) begin
         was_high_ff <= was_high_in;
         tick_ff     <= tick_in;
         period_ff   <= period_in;
         gated_ff    <= gated_in;
         unity_ff    <= unity_in;
      end
   end

   // Sequencer: load the dividends on accept, then one bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_DIV;
                  step_ff  <= '0;
               end
            end
            ST_DIV: begin
               if (!last_step) begin
                  step_ff <= step_ff + 1'b1;
               end else if (can_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Divider datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         num_main_ff <= {{MULT_WIDTH{1'b0}}, tick_in}
                        * {{COUNT_WIDTH{1'b0}}, main_mult_ff, 1'b0};
         num_mod_ff  <= {{MULT_WIDTH{1'b0}}, tick_in}
                        * {{COUNT_WIDTH{1'b0}}, mod_mult2};
         rem_main_ff <= '0;
         rem_mod_ff  <= '0;
         divisor_ff  <= (period_in == '0) ? COUNT_WIDTH'(1) : period_in;
         sample_ff   <= req_clk_sample;
      end else if (state_ff == ST_DIV && !last_step) begin
         num_main_ff <= {num_main_ff[NUM_WIDTH-2:0], 1'b0};
         num_mod_ff  <= {num_mod_ff[NUM_WIDTH-2:0], 1'b0};
         rem_main_ff <= rem_main_in;
         rem_mod_ff  <= rem_mod_in;
      end
   end

   // Output register: loaded at the last step, cleared once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DIV && last_step && can_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && last_step && can_load) begin
         out_sample_ff <= sample_ff;
         out_main_ff   <= !q_main;
         out_level_ff  <= level_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_through_sample = out_sample_ff;
   assign rsp_main_high      = out_main_ff;
   assign rsp_modified_level = out_level_ff;

endmodule

// ----- sim/pcm_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the probabilistic clock multiplier: follows register writes,
// predicts every result from the accepted items and compares. Depends on pcm_pkg.
module pcm_result_checker
   import pcm_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [11:0]               req_clk_sample,
   input  logic        [15:0]               req_rand_pass,
   input  logic        [15:0]               req_rand_mult,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [11:0]               rsp_through_sample,
   input  logic                             rsp_main_high,
   input  logic        [1:0]                rsp_modified_level,
   input  logic                             csr_write_en,
   input  logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [CSR_DATA_WIDTH-1:0] csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);

   typedef struct packed {
      logic signed [11:0] sample;
      logic               main_high;
      logic [1:0]         level;
   } multiplier_result_type;

   // Results predicted for accepted items, oldest first.
   multiplier_result_type expected_levels[$];

   // Shadow copy of the registers.
   logic signed [11:0] threshold;
   logic [4:0]         main_factor;
   logic [4:0]         block_factor;
   logic [16:0]        pass_limit;
   logic [16:0]        mult_limit;

   // Shadow copy of the tracking state.
   logic                   clock_high_seen;
   logic [COUNT_WIDTH-1:0] ticks;
   logic [COUNT_WIDTH-1:0] period;
   logic                   gated;
   logic                   unity;

   // A square wave at factor times the measured rate is high while the
   // quotient 2*factor*ticks/period is even.
   function automatic logic square_wave_high(input logic [4:0] factor,
                                             input logic [COUNT_WIDTH-1:0] count,
                                             input logic [COUNT_WIDTH-1:0] per);
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (per == '0) ? 64'd1 : 64'(per);
      quotient = (64'd2 * 64'(factor) * 64'(count)) / divisor;
      return ~quotient[0];
   endfunction

   // Advances the tracking state by one tick and works out the outputs.
   task automatic predict_levels(input logic signed [11:0] sample,
                                 input logic [15:0] rpass,
                                 input logic [15:0] rmult,
                                 output multiplier_result_type result);
      logic high;
      high = sample > threshold;
      if (ticks != COUNT_MAX) ticks = ticks + 1'b1;
      // A rising edge closes the period and draws the mode of the next one.
      if (high && !clock_high_seen) begin
         gated  = {1'b0, rpass} > pass_limit;
         unity  = {1'b0, rmult} > mult_limit;
         period = ticks;
         ticks  = '0;
      end
      clock_high_seen = high;
      result.sample    = sample;
      result.main_high = square_wave_high(main_factor, ticks, period);
      if (gated) begin
         result.level = LEVEL_LOW;
      end else if (unity) begin
         result.level = square_wave_high(5'd1, ticks, period) ? LEVEL_UNITY : LEVEL_LOW;
      end else begin
         result.level = square_wave_high(block_factor, ticks, period) ? LEVEL_MULT
                                                                      : LEVEL_LOW;
      end
   endtask

   always @(posedge clock) begin
      multiplier_result_type predicted;
      multiplier_result_type want;
      if (reset) begin
         threshold       = THRESHOLD_RESET;
         main_factor     = MULT_RESET;
         block_factor    = MULT_RESET;
         pass_limit      = PROB_RESET;
         mult_limit      = PROB_RESET;
         clock_high_seen = 1'b0;
         ticks           = COUNT_WIDTH'(1);
         period          = COUNT_WIDTH'(1);
         gated           = 1'b1;
         unity           = 1'b1;
         fail_count      = 0;
         expected_levels.delete();
      end else begin
         // Register writes only happen while the block is idle.
         if (csr_write_en) begin
            case (csr_index)
               REG_CLOCK_THRESHOLD: threshold    = csr_wdata[11:0];
               REG_MAIN_MULT:       main_factor  = csr_wdata[4:0];
               REG_BLOCK_MULT:      block_factor = csr_wdata[4:0];
               REG_PASS_PROB:       pass_limit   = csr_wdata[16:0];
               REG_MULT_PROB:       mult_limit   = csr_wdata[16:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_levels(req_clk_sample, req_rand_pass, req_rand_mult, predicted);
            expected_levels.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: result with no item waiting: sample %0d main %0b level %0d",
                        $time, rsp_through_sample, rsp_main_high, rsp_modified_level);
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_through_sample !== want.sample) begin
                  $display("%0t: through_sample expected %0d got %0d",
                           $time, want.sample, rsp_through_sample);
                  fail_count++;
               end
               if (rsp_main_high !== want.main_high) begin
                  $display("%0t: main_high expected %0b got %0b",
                           $time, want.main_high, rsp_main_high);
                  fail_count++;
               end
               if (rsp_modified_level !== want.level) begin
                  $display("%0t: modified_level expected %0d got %0d",
                           $time, want.level, rsp_modified_level);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_levels.size();
   end

endmodule

// ----- sim/probabilistic_clock_multiplier_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the probabilistic clock multiplier: drives clock-like sample
// sequences and register settings, and gives the verdict. Depends on pcm_pkg,
// pcm_result_checker and the block itself.
module probabilistic_clock_multiplier_unit_tb;
   import pcm_pkg::*;

   localparam int RANDOM_ITEMS   = 1450;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 2 * NUM_WIDTH;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [11:0]         req_clk_sample = '0;
   logic        [15:0]         req_rand_pass = '0;
   logic        [15:0]         req_rand_mult = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [11:0]         rsp_through_sample;
   logic                       rsp_main_high;
   logic        [1:0]          rsp_modified_level;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;
   int items_sent = 0;
   // While set, neither side idles.
   bit calm = 1'b0;
   int hold_left = 0;
   int run_left = 0;

   probabilistic_clock_multiplier_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clk_sample     (req_clk_sample),
      .req_rand_pass      (req_rand_pass),
      .req_rand_mult      (req_rand_mult),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_through_sample (rsp_through_sample),
      .rsp_main_high      (rsp_main_high),
      .rsp_modified_level (rsp_modified_level),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   pcm_result_checker result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clk_sample     (req_clk_sample),
      .req_rand_pass      (req_rand_pass),
      .req_rand_mult      (req_rand_mult),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_through_sample (rsp_through_sample),
      .rsp_main_high      (rsp_main_high),
      .rsp_modified_level (rsp_modified_level),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always #10 clock = ~clock;

   // Gap length before an item: mostly none or short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offers one item after a random gap and returns once it is accepted.
   task automatic send_item(input logic signed [11:0] sample,
                            input logic [15:0] rpass,
                            input logic [15:0] rmult);
      repeat (pick_gap()) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_clk_sample <= sample;
      req_rand_pass  <= rpass;
      req_rand_mult  <= rmult;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Holds the sender off until every expected result has come.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input logic signed [11:0] thr, input logic [4:0] main_m,
                            input logic [4:0] block_m, input logic [16:0] pass_p,
                            input logic [16:0] mult_p);
      write_reg(REG_CLOCK_THRESHOLD, {5'b0, thr});
      write_reg(REG_MAIN_MULT, {12'b0, main_m});
      write_reg(REG_BLOCK_MULT, {12'b0, block_m});
      write_reg(REG_PASS_PROB, pass_p);
      write_reg(REG_MULT_PROB, mult_p);
   endtask

   // Result side stall: runs of ready cycles broken by stalls of random length.
   always @(negedge clock) begin
      int roll;
      if (calm) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         roll     = $urandom_range(0, 99);
         run_left = $urandom_range(0, 12);
         if (roll < 60) hold_left = 0;
         else if (roll < 92) hold_left = $urandom_range(1, 3);
         else if (roll < 98) hold_left = $urandom_range(4, 15);
         else hold_left = $urandom_range(20, 80);
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      do begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end while (quiet_cycles < WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("probabilistic_clock_multiplier_unit test failed");
      $finish;
   end

   initial begin
      int thr_val;
      int roll;
      int phase_items;
      int wave_period;
      int high_len;
      int wave_pos;
      int pause_at;
      int sample_val;
      bit stopped;
      bit want_high;
      logic [4:0]  main_m;
      logic [4:0]  block_m;
      logic [16:0] pass_p;
      logic [16:0] mult_p;
      logic [15:0] rpass;
      logic [15:0] rmult;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: edges at the sample extremes and right at the threshold.
      send_item(-12'sd2048, 16'd0, 16'd0);
      send_item(12'sd2047, 16'hFFFF, 16'hFFFF);
      send_item(12'sd2047, 16'd0, 16'd0);
      send_item(12'sd410, 16'd0, 16'd0);
      send_item(12'sd411, 16'd0, 16'd0);
      send_item(12'sd0, 16'hFFFF, 16'd0);
      // Stopped clock: the count runs on past the period.
      repeat (5) send_item(-12'sd100, 16'd0, 16'd0);

      // Lowest threshold, zero factors and zero probabilities.
      wait_idle();
      configure(-12'sd2048, 5'd0, 5'd0, 17'd0, 17'd0);
      send_item(-12'sd2048, 16'd0, 16'hFFFF);
      send_item(-12'sd2047, 16'd0, 16'hFFFF);
      send_item(-12'sd2048, 16'd1, 16'd1);
      send_item(12'sd100, 16'd1, 16'd1);
      send_item(-12'sd2048, 16'd0, 16'd0);
      send_item(12'sd5, 16'd0, 16'd0);

      // Highest threshold: the clock never counts high.
      wait_idle();
      configure(12'sd2047, 5'd31, 5'd31, 17'h1FFFF, 17'h1FFFF);
      send_item(12'sd2047, 16'hFFFF, 16'hFFFF);
      send_item(-12'sd2048, 16'hFFFF, 16'hFFFF);

      // Probabilities above and at the largest random word.
      wait_idle();
      configure(12'sd2046, 5'd16, 5'd16, 17'd65537, 17'd65535);
      send_item(-12'sd2048, 16'd0, 16'd0);
      send_item(12'sd2047, 16'hFFFF, 16'hFFFF);
      repeat (3) send_item(-12'sd2048, 16'd0, 16'd0);

      // Random phases: a fresh setting each, then a clock wave with jitter and noise.
      while (items_sent < RANDOM_ITEMS) begin
         wait_idle();
         roll = $urandom_range(0, 9);
         if (roll == 0) thr_val = -2048;
         else if (roll == 1) thr_val = 2047;
         else if (roll == 2) thr_val = 410;
         else thr_val = int'($urandom_range(0, 4095)) - 2048;
         roll = $urandom_range(0, 9);
         main_m = (roll == 0) ? 5'd0 : (roll == 1) ? 5'd31 : (roll == 2) ? 5'd16
                : 5'($urandom_range(1, 16));
         roll = $urandom_range(0, 9);
         block_m = (roll == 0) ? 5'd0 : (roll == 1) ? 5'd31 : (roll == 2) ? 5'd16
                 : 5'($urandom_range(0, 16));
         roll = $urandom_range(0, 9);
         pass_p = (roll < 2) ? 17'd0 : (roll < 4) ? 17'd65536 : (roll == 4) ? 17'd65535
                : (roll == 5) ? 17'($urandom_range(65537, 131071))
                : 17'($urandom_range(0, 65536));
         roll = $urandom_range(0, 9);
         mult_p = (roll < 2) ? 17'd0 : (roll < 4) ? 17'd65536 : (roll == 4) ? 17'd65535
                : (roll == 5) ? 17'($urandom_range(65537, 131071))
                : 17'($urandom_range(0, 65536));
         configure(12'(thr_val), main_m, block_m, pass_p, mult_p);

         calm        = ($urandom_range(0, 4) == 0);
         stopped     = ($urandom_range(0, 19) == 0);
         phase_items = $urandom_range(40, 140);
         // The last phase stops at the item budget.
         if (phase_items > RANDOM_ITEMS - items_sent) phase_items = RANDOM_ITEMS - items_sent;
         pause_at    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, phase_items - 1) : -1;
         wave_period = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 24)
                                                  : $urandom_range(25, 120);
         high_len    = $urandom_range(1, wave_period - 1);
         wave_pos    = $urandom_range(0, wave_period - 1);

         for (int k = 0; k < phase_items; k++) begin
            if (k == pause_at) wait_idle();
            // Now and then the clock period drifts at the start of a cycle.
            if (wave_pos == 0 && $urandom_range(0, 9) == 0) begin
               wave_period = $urandom_range(2, 40);
               high_len    = $urandom_range(1, wave_period - 1);
            end
            want_high = !stopped && (wave_pos < high_len);
            if ($urandom_range(0, 99) < 8)
               sample_val = int'($urandom_range(0, 4095)) - 2048;
            else if (want_high && thr_val < 2047)
               sample_val = thr_val + 1 + int'($urandom_range(0, 2046 - thr_val));
            else
               sample_val = -2048 + int'($urandom_range(0, thr_val + 2048));
            roll  = $urandom_range(0, 9);
            rpass = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            roll  = $urandom_range(0, 9);
            rmult = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            send_item(12'(sample_val), rpass, rmult);
            wave_pos = (wave_pos + 1) % wave_period;
         end
         calm = 1'b0;
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("probabilistic_clock_multiplier_unit test passed");
      else
         $display("probabilistic_clock_multiplier_unit test failed");
      $finish;
   end

endmodule
